// ===== hw/rtl/dfa_pkg.sv =====
// Shared types, codes and sizes for the table-driven word recognizer.
package dfa_pkg;

   localparam int DFA_NUM_STATES  = 16;
   localparam int DFA_SYMBOL_BITS = 8;

   localparam int STATE_W   = 4;
   localparam int SYMBOL_W  = 8;
   localparam int CMD_W     = 2;
   localparam int VERDICT_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DW    = 16;
   localparam int ENTRY_W   = STATE_W + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_FEED  = 2'd1,
      CMD_EMPTY = 2'd2
   } cmd_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_NONE   = 2'd0,
      VERDICT_ACCEPT = 2'd1,
      VERDICT_REJECT = 2'd2,
      VERDICT_BLOCK  = 2'd3
   } verdict_type;

   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_MASK  = 1'b1;

   // Outcome of one request, also the automaton state it leaves behind.
   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic               blocked;
      logic               active;
      verdict_type        verdict;
      logic               done;
      logic [STATE_W-1:0] present;
   } step_type;

endpackage

// ===== hw/rtl/dfa_tbl.sv =====
// Transition table memory with registered read and a clearing sweep after reset.
module dfa_tbl
   import dfa_pkg::*;
#(
   parameter int NUM_STATES  = DFA_NUM_STATES,
   parameter int SYMBOL_BITS = DFA_SYMBOL_BITS,
   localparam int DEPTH = NUM_STATES * (1 << SYMBOL_BITS),
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [ENTRY_W-1:0] rd_data,
   output logic               busy
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic               clearing_ff, clearing_in;
   logic [ENTRY_W-1:0] rd_data_ff;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clearing_ff <= clearing_in;
      end
   end

   // Sweep zeros through every entry, then take the request write port.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

// ===== hw/rtl/dfa_step.sv =====
// Next-state and verdict logic for one request of the recognizer.
module dfa_step
   import dfa_pkg::*;
#(
   parameter int NUM_STATES = DFA_NUM_STATES
) (
   input  cmd_type              cmd,
   input  logic                 last,
   input  logic [ENTRY_W-1:0]   entry,
   input  logic [STATE_W-1:0]   state,
   input  logic                 blocked,
   input  logic                 active,
   input  logic [STATE_W-1:0]   start_state,
   input  logic [CSR_DW-1:0]    final_mask,
   output step_type             result
);

   logic [STATE_W-1:0] word_state;
   logic               word_blocked;
   logic               hit;

   always_comb begin
      word_state   = active ? state : start_state;
      word_blocked = active ? blocked : 1'b0;
      hit          = entry[ENTRY_W-1] && (int'(word_state) < NUM_STATES);

      result.state   = state;
      result.blocked = blocked;
      result.active  = active;
      result.verdict = VERDICT_NONE;
      result.done    = 1'b0;
      result.present = blocked ? '0 : state;

      case (cmd)
         CMD_FEED: begin
            result.state   = word_state;
            result.blocked = word_blocked;
            result.active  = 1'b1;
            if (!word_blocked) begin
               if (hit) begin
                  result.state = entry[STATE_W-1:0];
               end else begin
                  result.blocked = 1'b1;
               end
            end
            result.present = result.blocked ? '0 : result.state;
            if (last) begin
               result.done = 1'b1;
               if (result.blocked) begin
                  result.verdict = VERDICT_BLOCK;
                  result.state   = '0;
               end else if (final_mask[result.state]) begin
                  result.verdict = VERDICT_ACCEPT;
               end else begin
                  result.verdict = VERDICT_REJECT;
               end
               result.blocked = 1'b0;
               result.active  = 1'b0;
            end
         end
         CMD_EMPTY: begin
            result.state   = start_state;
            result.blocked = 1'b0;
            result.active  = 1'b0;
            result.done    = 1'b1;
            result.present = start_state;
            result.verdict = final_mask[start_state] ? VERDICT_ACCEPT : VERDICT_REJECT;
         end
         default: begin
            // table writes and the unused code leave the word untouched
         end
      endcase
   end

endmodule

// ===== hw/rtl/dfa_word_recognizer.sv =====
// Top level of the table-driven word recognizer: request stage, table, response register.
//
// Usage
//   Requests arrive on req_* (valid/ready). req_command selects a table
//   write (from_state, symbol -> to_state), one symbol of a word (req_last
//   marks its end) or evaluation of the empty word. Every request yields
//   exactly one response on rsp_* (valid/ready): verdict, word_done and
//   the automaton state after the request. The csr_* port writes the start state
//   (index 0) and the final-state mask (index 1); write them only while idle, the
//   block does not enforce it. Each request passes the request stage, then the
//   response register. Throughput: one request per cycle while rsp_ready is high
//   and the table is not being cleared. The table read for a symbol is issued on
//   the accept edge, addressed by the state the previous request leaves behind, so
//   the loop through the table's read port and the next-state logic sets the rate.
//   Reset: clears the word state and the control registers, then sweeps all
//   NUM_STATES * 2**SYMBOL_BITS table entries (4096 by default) clear, during
//   which req_ready stays low; csr writes are taken throughout.
//   Stall: while rsp_ready is low the response register holds and one
//   more request may wait in the request stage; req_ready then drops.
module dfa_word_recognizer
   import dfa_pkg::*;
#(
   parameter int NUM_STATES  = DFA_NUM_STATES,
   parameter int SYMBOL_BITS = DFA_SYMBOL_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [STATE_W-1:0]   req_from_state,
   input  logic [SYMBOL_W-1:0]  req_symbol,
   input  logic [STATE_W-1:0]   req_to_state,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VERDICT_W-1:0] rsp_verdict,
   output logic                 rsp_word_done,
   output logic [STATE_W-1:0]   rsp_present_state,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DW-1:0]    csr_wdata
);

   localparam int DEPTH = NUM_STATES * (1 << SYMBOL_BITS);
   localparam int AW    = $clog2(DEPTH);

   // architectural state and configuration
   logic [STATE_W-1:0] state_ff, state_in;
   logic               blocked_ff, blocked_in;
   logic               active_ff, active_in;
   logic [STATE_W-1:0] start_state_ff;
   logic [CSR_DW-1:0]  final_mask_ff;

   // request stage
   logic               s1_valid_ff, s1_valid_in;
   cmd_type            s1_cmd_ff;
   logic               s1_last_ff;
   logic               s1_move;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   verdict_type          rsp_verdict_ff;
   logic                 rsp_done_ff;
   logic [STATE_W-1:0]   rsp_present_ff;

   logic               req_accept;
   logic               tbl_busy;
   logic [ENTRY_W-1:0] tbl_rd_data;
   logic               tbl_wr_en;
   logic [AW-1:0]      tbl_wr_addr;
   logic               tbl_rd_en;
   logic [AW-1:0]      tbl_rd_addr;
   logic [STATE_W-1:0] lookup_state;
   step_type           step;

   // Advance the request stage whenever the response register is free or drains.
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !tbl_busy && (!s1_valid_ff || s1_move);
   assign req_accept = req_valid && req_ready;

   dfa_step #(
      .NUM_STATES (NUM_STATES)
   ) u_step (
      .cmd         (s1_cmd_ff),
      .last        (s1_last_ff),
      .entry       (tbl_rd_data),
      .state       (state_ff),
      .blocked     (blocked_ff),
      .active      (active_ff),
      .start_state (start_state_ff),
      .final_mask  (final_mask_ff),
      .result      (step)
   );

   // Look up from the state the request now in the stage leaves behind;
   // a new word starts from the start state.
   always_comb begin
      state_in   = state_ff;
      blocked_in = blocked_ff;
      active_in  = active_ff;
      if (s1_valid_ff) begin
         state_in   = step.state;
         blocked_in = step.blocked;
         active_in  = step.active;
      end
      lookup_state = active_in ? state_in : start_state_ff;
   end

   assign tbl_rd_en   = req_accept && (req_command == CMD_FEED)
                        && (int'(lookup_state) < NUM_STATES);
   assign tbl_rd_addr = AW'({lookup_state, req_symbol[SYMBOL_BITS-1:0]});
   assign tbl_wr_en   = req_accept && (req_command == CMD_WRITE)
                        && (int'(req_from_state) < NUM_STATES);
   assign tbl_wr_addr = AW'({req_from_state, req_symbol[SYMBOL_BITS-1:0]});

   dfa_tbl #(
      .NUM_STATES  (NUM_STATES),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_tbl (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data ({1'b1, req_to_state}),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data),
      .busy    (tbl_busy)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= '0;
         blocked_ff     <= 1'b0;
         active_ff      <= 1'b0;
         start_state_ff <= '0;
         final_mask_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            state_ff   <= state_in;
            blocked_ff <= blocked_in;
            active_ff  <= active_in;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_START_STATE: start_state_ff <= csr_wdata[STATE_W-1:0];
               CSR_FINAL_MASK:  final_mask_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload: hold while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff  <= cmd_type'(req_command);
         s1_last_ff <= req_last;
      end
      if (s1_move) begin
         rsp_verdict_ff <= step.verdict;
         rsp_done_ff    <= step.done;
         rsp_present_ff <= step.present;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_word_done     = rsp_done_ff;
   assign rsp_present_state = rsp_present_ff;

   // No request enters while the table is being cleared.
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      tbl_busy |-> !req_ready)
      else $error("request accepted during table clear");

   // A word can only be blocked while it is in progress.
   a_blocked_in_word: assert property (@(posedge clock) disable iff (reset)
      blocked_ff |-> active_ff)
      else $error("blocked flag set outside a word");

   // A finished word always carries a verdict, an unfinished one never.
   a_done_has_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_done_ff == (rsp_verdict_ff != VERDICT_NONE)))
      else $error("verdict does not match word_done");

   // Finishing a word closes it.
   a_done_closes_word: assert property (@(posedge clock) disable iff (reset)
      (s1_move && step.done) |=> (!active_ff && !blocked_ff))
      else $error("word still open after its verdict");

endmodule
